// ===== design/qrs_pkg.sv =====
`timescale 1ns / 1ps
package qrs_pkg;

   localparam int COEF_W = 16;
   localparam int DISC_W = 34;            // magnitude of a non-negative discriminant
   localparam int ROOT_W = DISC_W / 2;    // integer square root
   localparam int SREM_W = ROOT_W + 2;    // square-root partial remainder
   localparam int DEN_W  = COEF_W + 1;    // |2a|
   localparam int NUM_W  = ROOT_W + 1;    // |-b +/- s|
   localparam int QUO_W  = NUM_W + 16;    // numerator scaled to Q16.16
   localparam int RES_W  = 32;
   localparam int LATENCY = 3 + ROOT_W + 1 + QUO_W + 1;

   typedef enum logic [1:0] {
      ST_REAL    = 2'd0,
      ST_COMPLEX = 2'd1,
      ST_AZERO   = 2'd2
   } status_type;

   typedef struct packed {
      logic                     valid;
      status_type               status;
      logic                     den_neg;
      logic [DEN_W-1:0]         den_mag;
      logic signed [COEF_W-1:0] coef_b;
      logic [DISC_W-1:0]        disc;
   } side_type;

   typedef struct packed {
      logic [SREM_W-1:0] rem;
      logic [ROOT_W-1:0] root;
   } sqrt_type;

   typedef struct packed {
      logic              valid;
      status_type        status;
      logic [DEN_W-1:0]  den_mag;
   } dside_type;

   typedef struct packed {
      logic              neg;
      logic [NUM_W-1:0]  num;
      logic [DEN_W-1:0]  rem;
      logic [QUO_W-1:0]  quo;
   } lane_type;

   // One restoring long-division step: bring down one numerator bit.
   function automatic lane_type div_lane(lane_type l, logic [DEN_W-1:0] den, logic nb);
      logic [DEN_W:0] rsh;
      lane_type       r;
      rsh = {l.rem, nb};
      r   = l;
      if (rsh >= {1'b0, den}) begin
         r.rem = DEN_W'(rsh - {1'b0, den});
         r.quo = {l.quo[QUO_W-2:0], 1'b1};
      end else begin
         r.rem = rsh[DEN_W-1:0];
         r.quo = {l.quo[QUO_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

// ===== design/qrs_sqrt_step.sv =====
`timescale 1ns / 1ps
module qrs_sqrt_step
   import qrs_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  side_type side_in,
   input  sqrt_type sq_in,
   output side_type side_out,
   output sqrt_type sq_out
);

   side_type          side_ff;
   sqrt_type          sq_ff, sq_in_n;
   logic [SREM_W+1:0] rsh;
   logic [SREM_W+1:0] trial;

   always_comb begin
      rsh   = {sq_in.rem, side_in.disc[2*STEP+1 -: 2]};
      trial = (SREM_W+2)'({sq_in.root, 2'b01});
      if (rsh >= trial) begin
         sq_in_n.rem  = SREM_W'(rsh - trial);
         sq_in_n.root = {sq_in.root[ROOT_W-2:0], 1'b1};
      end else begin
         sq_in_n.rem  = SREM_W'(rsh);
         sq_in_n.root = {sq_in.root[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      sq_ff <= sq_in_n;
      if (reset) side_ff <= '0;
      else       side_ff <= side_in;
   end

   assign side_out = side_ff;
   assign sq_out   = sq_ff;

endmodule

// ===== design/qrs_div_step.sv =====
`timescale 1ns / 1ps
module qrs_div_step
   import qrs_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  dside_type side_in,
   input  lane_type  plus_in,
   input  lane_type  minus_in,
   output dside_type side_out,
   output lane_type  plus_out,
   output lane_type  minus_out
);

   localparam int NBIT = STEP - 16;

   dside_type side_ff;
   lane_type  plus_ff, minus_ff;
   logic      nb_p, nb_m;

   // numerator is num << 16: low 16 bits are zero
   always_comb begin
      if (NBIT >= 0) begin
         nb_p = plus_in.num[NBIT >= 0 ? NBIT : 0];
         nb_m = minus_in.num[NBIT >= 0 ? NBIT : 0];
      end else begin
         nb_p = 1'b0;
         nb_m = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      plus_ff  <= div_lane(plus_in, side_in.den_mag, nb_p);
      minus_ff <= div_lane(minus_in, side_in.den_mag, nb_m);
      if (reset) side_ff <= '0;
      else       side_ff <= side_in;
   end

   assign side_out  = side_ff;
   assign plus_out  = plus_ff;
   assign minus_out = minus_ff;

endmodule

// ===== design/quadratic_real_root_solver.sv =====
`timescale 1ns / 1ps
// channel   direction  transfer condition      payload
// req       in         start && !busy          req_coef_a, req_coef_b, req_coef_c
// rsp       out        rsp_valid (one cycle)   rsp_root_plus, rsp_root_minus,
//                                               rsp_root_status, rsp_saturated
// One equation enters every cycle; results transfer in request order.
// The pipeline is mostly the 17-step square-root pipeline and the 34-step
// divider pipeline, one result bit per stage.
// Synchronous reset clears the valid bits of every stage.
// busy stays low: the pipeline never stalls, and the receiver cannot stall.
module quadratic_real_root_solver
   import qrs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [COEF_W-1:0] req_coef_a,
   input  logic signed [COEF_W-1:0] req_coef_b,
   input  logic signed [COEF_W-1:0] req_coef_c,
   output logic                     rsp_valid,
   output logic signed [RES_W-1:0]  rsp_root_plus,
   output logic signed [RES_W-1:0]  rsp_root_minus,
   output logic [1:0]               rsp_root_status,
   output logic                     rsp_saturated
);

   // stage 0: capture
   logic                     v0_ff;
   logic signed [COEF_W-1:0] a0_ff, b0_ff, c0_ff;
   // stage 1: products
   logic                       v1_ff;
   logic signed [COEF_W-1:0]   a1_ff, b1_ff;
   logic signed [2*COEF_W-1:0] bb1_ff, ac1_ff;
   // stage 2: discriminant
   side_type           side2_in;
   side_type           side2_ff;
   logic signed [DISC_W:0] disc_s;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      a0_ff  <= req_coef_a;
      b0_ff  <= req_coef_b;
      c0_ff  <= req_coef_c;
      a1_ff  <= a0_ff;
      b1_ff  <= b0_ff;
      bb1_ff <= b0_ff * b0_ff;
      ac1_ff <= a0_ff * c0_ff;
      if (reset) begin
         v0_ff    <= 1'b0;
         v1_ff    <= 1'b0;
         side2_ff <= '0;
      end else begin
         v0_ff    <= start;
         v1_ff    <= v0_ff;
         side2_ff <= side2_in;
      end
   end

   always_comb begin
      disc_s           = (DISC_W+1)'(bb1_ff) - ((DISC_W+1)'(ac1_ff) <<< 2);
      side2_in.valid   = v1_ff;
      side2_in.den_neg = a1_ff[COEF_W-1];
      side2_in.den_mag = a1_ff[COEF_W-1] ? DEN_W'(-{a1_ff[COEF_W-1], a1_ff}) << 1
                                          : DEN_W'({a1_ff[COEF_W-1], a1_ff}) << 1;
      side2_in.coef_b  = b1_ff;
      side2_in.disc    = disc_s[DISC_W-1:0];
      if (a1_ff == '0)            side2_in.status = ST_AZERO;
      else if (disc_s[DISC_W])    side2_in.status = ST_COMPLEX;
      else                        side2_in.status = ST_REAL;
      if (side2_in.status != ST_REAL) side2_in.disc = '0;
   end

   // square root, most significant result bit first
   side_type sside [ROOT_W+1];
   sqrt_type ssq   [ROOT_W+1];

   assign sside[0] = side2_ff;
   assign ssq[0]   = '0;

   for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
      qrs_sqrt_step #(.STEP(ROOT_W - 1 - i)) u_step (
         .clock    (clock),
         .reset    (reset),
         .side_in  (sside[i]),
         .sq_in    (ssq[i]),
         .side_out (sside[i+1]),
         .sq_out   (ssq[i+1])
      );
   end

   // numerators -b + s and -b - s as sign and magnitude
   side_type          sfin;
   logic signed [NUM_W:0] bx, sx, np, nm;
   dside_type dside_in_n, dside_ff;
   lane_type  lp_in, lm_in, lp_ff, lm_ff;

   assign sfin = sside[ROOT_W];

   always_comb begin
      bx = (NUM_W+1)'(sfin.coef_b);
      sx = $signed({2'b00, ssq[ROOT_W].root});
      np = sx - bx;
      nm = -sx - bx;
      dside_in_n.valid   = sfin.valid;
      dside_in_n.status  = sfin.status;
      dside_in_n.den_mag = sfin.den_mag;
      lp_in.neg = np[NUM_W] ^ sfin.den_neg;
      lp_in.num = np[NUM_W] ? NUM_W'(-np) : np[NUM_W-1:0];
      lp_in.rem = '0;
      lp_in.quo = '0;
      lm_in.neg = nm[NUM_W] ^ sfin.den_neg;
      lm_in.num = nm[NUM_W] ? NUM_W'(-nm) : nm[NUM_W-1:0];
      lm_in.rem = '0;
      lm_in.quo = '0;
   end

   always_ff @(posedge clock) begin
      lp_ff <= lp_in;
      lm_ff <= lm_in;
      if (reset) dside_ff <= '0;
      else       dside_ff <= dside_in_n;
   end

   dside_type dside [QUO_W+1];
   lane_type  dlp   [QUO_W+1];
   lane_type  dlm   [QUO_W+1];

   assign dside[0] = dside_ff;
   assign dlp[0]   = lp_ff;
   assign dlm[0]   = lm_ff;

   for (genvar j = 0; j < QUO_W; j++) begin : g_div
      qrs_div_step #(.STEP(QUO_W - 1 - j)) u_step (
         .clock     (clock),
         .reset     (reset),
         .side_in   (dside[j]),
         .plus_in   (dlp[j]),
         .minus_in  (dlm[j]),
         .side_out  (dside[j+1]),
         .plus_out  (dlp[j+1]),
         .minus_out (dlm[j+1])
      );
   end

   // apply sign and clip to Q16.16
   localparam logic [QUO_W-1:0] POS_LIM = QUO_W'(32'h7FFF_FFFF);
   localparam logic [QUO_W-1:0] NEG_LIM = QUO_W'(33'h0_8000_0000);

   logic                    valid_ff, sat_ff;
   logic signed [RES_W-1:0] rp_ff, rm_ff;
   status_type              status_ff;
   logic                    sat_p, sat_m;
   logic signed [RES_W-1:0] rp_n, rm_n;

   function automatic logic signed [RES_W-1:0] clip(lane_type l, output logic sat);
      logic [QUO_W-1:0] neg_q;
      neg_q = -l.quo;
      sat   = 1'b0;
      if (!l.neg) begin
         if (l.quo > POS_LIM) begin
            sat  = 1'b1;
            return RES_W'(POS_LIM);
         end
         return l.quo[RES_W-1:0];
      end
      if (l.quo > NEG_LIM) begin
         sat = 1'b1;
         return NEG_LIM[RES_W-1:0];
      end
      return neg_q[RES_W-1:0];
   endfunction

   always_comb begin
      rp_n = clip(dlp[QUO_W], sat_p);
      rm_n = clip(dlm[QUO_W], sat_m);
   end

   always_ff @(posedge clock) begin
      status_ff <= dside[QUO_W].status;
      if (dside[QUO_W].status == ST_REAL) begin
         rp_ff  <= rp_n;
         rm_ff  <= rm_n;
         sat_ff <= sat_p | sat_m;
      end else begin
         rp_ff  <= '0;
         rm_ff  <= '0;
         sat_ff <= 1'b0;
      end
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= dside[QUO_W].valid;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_root_plus   = rp_ff;
   assign rsp_root_minus  = rm_ff;
   assign rsp_root_status = status_ff;
   assign rsp_saturated   = sat_ff;

endmodule

// ===== design/qrs_checker.sv =====
`timescale 1ns / 1ps
module qrs_checker
   import qrs_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic                    rsp_valid,
   input logic signed [RES_W-1:0] rsp_root_plus,
   input logic signed [RES_W-1:0] rsp_root_minus,
   input logic [1:0]              rsp_root_status,
   input logic                    rsp_saturated
);

   a_no_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("result without matching transfer");

   a_no_root: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_root_status != ST_REAL |->
         rsp_root_plus == '0 && rsp_root_minus == '0 && !rsp_saturated)
      else $error("nonzero roots without real status");

   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_root_plus == 32'sh7FFF_FFFF || rsp_root_plus == 32'sh8000_0000 ||
         rsp_root_minus == 32'sh7FFF_FFFF || rsp_root_minus == 32'sh8000_0000)
      else $error("saturation flag without clipped root");

endmodule

bind quadratic_real_root_solver qrs_checker u_qrs_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_root_plus   (rsp_root_plus),
   .rsp_root_minus  (rsp_root_minus),
   .rsp_root_status (rsp_root_status),
   .rsp_saturated   (rsp_saturated)
);
